/* rtl/aabb_pod_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pod_pkg
// Shared widths and the controller-to-datapath command bundle of the
// box pair overlap detector.
// ----------------------------------------------------------------------------
package aabb_pod_pkg;

  localparam int POS_W    = 24;  // signed Q16.8 position and offset
  localparam int SIZE_W   = 20;  // unsigned Q12.8 width and height
  localparam int SCALE_W  = 16;  // unsigned Q8.8 scale
  localparam int IDX_W    = 6;   // result index field width
  localparam int CORNER_W = 34;  // signed Q.8 corner, holds every reachable value

  // datapath pipeline depth from captured item to settled corners
  localparam int CALC_STEPS = 3;

  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_BOX   = 1'b1;

  localparam logic STATUS_PAIR = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  typedef struct packed {
    logic capture;  // load the request fields
    logic ram_re;   // read the corner table at rd_addr
    logic ram_we;   // store the new corners at wr_addr
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/aabb_pod_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pod_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module aabb_pod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/aabb_pod_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pod_dp
// Corner arithmetic pipeline, corner table and the overlap comparator.
// ----------------------------------------------------------------------------
module aabb_pod_dp #(
  parameter int MAX_BOXES = 32
) (
  input  wire logic                                clk,
  input  wire aabb_pod_pkg::cmd_t                  cmd,
  input  wire logic [aabb_pod_pkg::POS_W-1:0]      pos_x,
  input  wire logic [aabb_pod_pkg::POS_W-1:0]      pos_y,
  input  wire logic [aabb_pod_pkg::POS_W-1:0]      offset_x,
  input  wire logic [aabb_pod_pkg::POS_W-1:0]      offset_y,
  input  wire logic [aabb_pod_pkg::SIZE_W-1:0]     box_width,
  input  wire logic [aabb_pod_pkg::SIZE_W-1:0]     box_height,
  input  wire logic [aabb_pod_pkg::SCALE_W-1:0]    box_scale,
  input  wire logic [$clog2(MAX_BOXES)-1:0]        rd_addr,
  input  wire logic [$clog2(MAX_BOXES)-1:0]        wr_addr,
  output      logic                                hit
);

  localparam int PW  = aabb_pod_pkg::POS_W;
  localparam int SW  = aabb_pod_pkg::SIZE_W;
  localparam int KW  = aabb_pod_pkg::SCALE_W;
  localparam int CWD = aabb_pod_pkg::CORNER_W;
  localparam int OPW = PW + KW + 1;   // signed offset product
  localparam int SPW = SW + KW;       // unsigned size product
  localparam int SQW = SPW - 8;       // size product back in Q.8
  localparam int AW  = $clog2(MAX_BOXES);

  logic signed [PW-1:0]  px, py, ox, oy;
  logic        [SW-1:0]  bw, bh;
  logic        [KW-1:0]  sc;

  logic signed [OPW-1:0] prod_x, prod_y;
  logic        [SPW-1:0] prod_w, prod_h;

  logic signed [CWD-1:0] left, top, right, bottom;
  logic        [SQW-1:0] wsc, hsc;

  logic [4*CWD-1:0]      rdata;
  logic signed [CWD-1:0] s_left, s_top, s_right, s_bottom;

  // hold the request for the whole item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px <= pos_x;
      py <= pos_y;
      ox <= offset_x;
      oy <= offset_y;
      bw <= box_width;
      bh <= box_height;
      sc <= box_scale;
    end
  end

  // free-running pipeline fed by the captured request
  always_ff @(posedge clk) begin
    prod_x <= ox * $signed({1'b0, sc});
    prod_y <= oy * $signed({1'b0, sc});
    prod_w <= bw * sc;
    prod_h <= bh * sc;
  end

  // floor to Q.8 is an arithmetic drop of the low 8 bits
  always_ff @(posedge clk) begin
    left   <= {{(CWD-PW){px[PW-1]}}, px} + {{(CWD-OPW+8){prod_x[OPW-1]}}, prod_x[OPW-1:8]};
    top    <= {{(CWD-PW){py[PW-1]}}, py} + {{(CWD-OPW+8){prod_y[OPW-1]}}, prod_y[OPW-1:8]};
    wsc    <= prod_w[SPW-1:8];
    hsc    <= prod_h[SPW-1:8];
  end

  always_ff @(posedge clk) begin
    right  <= left + {{(CWD-SQW){1'b0}}, wsc};
    bottom <= top + {{(CWD-SQW){1'b0}}, hsc};
  end

  aabb_pod_ram #(
    .WIDTH (4*CWD),
    .DEPTH (MAX_BOXES)
  ) u_corner_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (wr_addr[AW-1:0]),
    .wdata ({bottom, right, top, left}),
    .re    (cmd.ram_re),
    .raddr (rd_addr[AW-1:0]),
    .rdata (rdata)
  );

  assign s_left   = rdata[CWD-1:0];
  assign s_top    = rdata[2*CWD-1:CWD];
  assign s_right  = rdata[3*CWD-1:2*CWD];
  assign s_bottom = rdata[4*CWD-1:3*CWD];

  // strict test: touching edges do not count
  assign hit = !((s_left >= right) || (left >= s_right) ||
                 (s_top >= bottom) || (top >= s_bottom));

endmodule
`default_nettype wire

/* rtl/aabb_pod_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pod_ctrl
// Sequencer: frame clear, full-table drop, corner wait, table store, one-entry-per-cycle scan that a full
// result register can stall, with a one-deep hold for the last-result mark, and the result register.
// ----------------------------------------------------------------------------
module aabb_pod_ctrl #(
  parameter int MAX_BOXES = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire logic                               in_kind,
  output      logic                               in_ready,
  input  wire logic                               hit,
  output      aabb_pod_pkg::cmd_t                 cmd,
  output      logic [$clog2(MAX_BOXES)-1:0]       rd_addr,
  output      logic [$clog2(MAX_BOXES)-1:0]       wr_addr,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic                               out_status,
  output      logic [aabb_pod_pkg::IDX_W-1:0]     out_older,
  output      logic [aabb_pod_pkg::IDX_W-1:0]     out_newer,
  output      logic                               out_last
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int IW = aabb_pod_pkg::IDX_W;
  localparam logic [CW-1:0] FULL      = CW'(MAX_BOXES);
  localparam logic [1:0]    CALC_LAST = 2'(aabb_pod_pkg::CALC_STEPS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_DROP  = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [1:0]    calc_cnt, calc_cnt_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic          cmp_valid, cmp_valid_next;
  logic [AW-1:0] cmp_idx, cmp_idx_next;
  logic          pend_valid, pend_valid_next;
  logic [AW-1:0] pend_idx, pend_idx_next;
  logic          out_valid_next, out_status_next, out_last_next;
  logic [IW-1:0] out_older_next, out_newer_next;
  logic          can_push, issue, stall;

  assign in_ready = (state == ST_IDLE);
  assign can_push = !out_valid || out_ready;
  assign rd_addr  = rd_idx[AW-1:0];
  assign wr_addr  = count[AW-1:0];

  always_comb begin
    state_next      = state;
    count_next      = count;
    calc_cnt_next   = calc_cnt;
    rd_idx_next     = rd_idx;
    cmp_valid_next  = cmp_valid;
    cmp_idx_next    = cmp_idx;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    out_valid_next  = out_valid && !out_ready;
    out_status_next = out_status;
    out_older_next  = out_older;
    out_newer_next  = out_newer;
    out_last_next   = out_last;
    cmd             = '0;
    issue           = 1'b0;
    stall           = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == aabb_pod_pkg::KIND_CLEAR) begin
            count_next = '0;
          end else if (count == FULL) begin
            state_next = ST_DROP;
          end else begin
            cmd.capture   = 1'b1;
            calc_cnt_next = '0;
            state_next    = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        calc_cnt_next = calc_cnt + 2'd1;
        if (calc_cnt == CALC_LAST) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.ram_we      = 1'b1;
        rd_idx_next     = '0;
        cmp_valid_next  = 1'b0;
        pend_valid_next = 1'b0;
        state_next      = ST_SCAN;
      end
      ST_SCAN: begin
        // a second hit with a pair still held needs room in the result register
        stall = cmp_valid && hit && pend_valid && !can_push;
        if (!stall) begin
          issue          = (rd_idx < count);
          cmd.ram_re     = issue;
          cmp_valid_next = issue;
          cmp_idx_next   = rd_idx[AW-1:0];
          if (issue) begin
            rd_idx_next = rd_idx + CW'(1);
          end
          if (cmp_valid && hit) begin
            if (pend_valid) begin
              out_valid_next  = 1'b1;
              out_status_next = aabb_pod_pkg::STATUS_PAIR;
              out_older_next  = IW'(pend_idx);
              out_newer_next  = IW'(count);
              out_last_next   = 1'b0;
            end
            pend_idx_next   = cmp_idx;
            pend_valid_next = 1'b1;
          end
          if (!issue && !cmp_valid) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          count_next = count + CW'(1);
          state_next = ST_IDLE;
        end else if (can_push) begin
          out_valid_next  = 1'b1;
          out_status_next = aabb_pod_pkg::STATUS_PAIR;
          out_older_next  = IW'(pend_idx);
          out_newer_next  = IW'(count);
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          count_next      = count + CW'(1);
          state_next      = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (can_push) begin
          out_valid_next  = 1'b1;
          out_status_next = aabb_pod_pkg::STATUS_DROP;
          out_older_next  = '0;
          out_newer_next  = '0;
          out_last_next   = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      cmp_valid  <= cmp_valid_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    calc_cnt   <= calc_cnt_next;
    rd_idx     <= rd_idx_next;
    cmp_idx    <= cmp_idx_next;
    pend_idx   <= pend_idx_next;
    out_status <= out_status_next;
    out_older  <= out_older_next;
    out_newer  <= out_newer_next;
    out_last   <= out_last_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("entry count beyond table size");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!pend_valid && !cmp_valid))
    else $error("scan left work behind");

  a_cmp_in_table: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (CW'(cmp_idx) < count))
    else $error("compare of an entry outside the table");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_we |-> (count < FULL))
    else $error("store into a full table");

  a_drop_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == aabb_pod_pkg::STATUS_DROP)) |->
      (out_last && (out_older == '0) && (out_newer == '0)))
    else $error("malformed drop result");

endmodule
`default_nettype wire

/* rtl/aabb_pair_overlap_detector_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Box request: not ready for a new request until the scan is done; the single read port of the corner
//   RAM scans one stored box per cycle, unless a full result register stalls the scan.
// A clear is taken in the idle state; a box into a full table emits a drop result.
// Reset clears the state, the entry count and the valid flags; the corner RAM is not cleared.
// ----------------------------------------------------------------------------
// aabb_pair_overlap_detector_top
// All-pairs axis-aligned box overlap detection in fixed point. Each box request
// forms its corners, is tested against every stored box of the frame, emits one
// result per overlapping pair and is then kept in the table, or is dropped if the table is full.
// ----------------------------------------------------------------------------
module aabb_pair_overlap_detector_top #(
  parameter int MAX_BOXES = 32   // table depth, 2 to 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // request channel
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  // pos_x[23:0], pos_y[47:24], offset_x[71:48], offset_y[95:72],
  // box_width[115:96], box_height[135:116], box_scale[151:136]
  input  wire logic [151:0] s_tdata,
  // kind[0]: 0 clears the table, 1 adds a box
  input  wire logic [0:0]   s_tuser,
  // result channel
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  // older_index[5:0], newer_index[11:6], zero fill [15:12]
  output      logic [15:0]  m_tdata,
  // status[0]: 0 overlapping pair, 1 box dropped on a full table
  output      logic [0:0]   m_tuser,
  // last_result: final result of the request
  output      logic         m_tlast
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int IW = aabb_pod_pkg::IDX_W;

  aabb_pod_pkg::cmd_t cmd;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               hit;
  logic [IW-1:0]      out_older, out_newer;
  logic               out_status;

  // Controller: owns the sequence, the entry count and the result register.
  aabb_pod_ctrl #(
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_kind    (s_tuser[0]),
    .in_ready   (s_tready),
    .hit        (hit),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_older  (out_older),
    .out_newer  (out_newer),
    .out_last   (m_tlast)
  );

  // Datapath: corner math, corner table and the overlap compare.
  aabb_pod_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .pos_x      (s_tdata[23:0]),
    .pos_y      (s_tdata[47:24]),
    .offset_x   (s_tdata[71:48]),
    .offset_y   (s_tdata[95:72]),
    .box_width  (s_tdata[115:96]),
    .box_height (s_tdata[135:116]),
    .box_scale  (s_tdata[151:136]),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .hit        (hit)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {4'b0000, out_newer, out_older};
  assign m_tuser = out_status;

endmodule
`default_nettype wire
